[rtl/acfb_pkg.sv]
// Package with AES-128 types, constants and round functions.
`timescale 1ns / 1ps
package acfb_pkg;

  typedef logic [127:0] block_t;

  typedef enum logic [2:0] {
    REG_KEY_HIGH  = 3'd0,
    REG_KEY_LOW   = 3'd1,
    REG_IV_HIGH   = 3'd2,
    REG_IV_LOW    = 3'd3,
    REG_DIRECTION = 3'd4
  } reg_idx_e;

  localparam logic [7:0] GfPoly = 8'h1b;
  localparam logic [7:0] RconInit = 8'h01;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] gf_dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? GfPoly : 8'h00);
  endfunction

  // byte i of a block sits at bits [127-8i -: 8]
  function automatic logic [7:0] get_byte(input block_t b, input int i);
    return b[127-8*i -: 8];
  endfunction

  function automatic block_t next_round_key(input block_t rk, input logic [7:0] rc);
    logic [7:0] k [16];
    logic [7:0] n [16];
    for (int i = 0; i < 16; i++) k[i] = get_byte(rk, i);
    n[0] = k[0] ^ SBOX[k[13]] ^ rc;
    n[1] = k[1] ^ SBOX[k[14]];
    n[2] = k[2] ^ SBOX[k[15]];
    n[3] = k[3] ^ SBOX[k[12]];
    for (int i = 4; i < 16; i++) n[i] = k[i] ^ n[i-4];
    return {n[0], n[1], n[2], n[3], n[4], n[5], n[6], n[7],
            n[8], n[9], n[10], n[11], n[12], n[13], n[14], n[15]};
  endfunction

  function automatic block_t cipher_round(input block_t s, input block_t rk,
                                          input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] o [16];
    logic [7:0] all;
    for (int i = 0; i < 16; i++) b[i] = get_byte(s, i);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[c*4+r] = SBOX[b[((c + r) % 4)*4 + r]];
    for (int c = 0; c < 4; c++) begin
      all = t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3];
      for (int r = 0; r < 4; r++) begin
        if (last) begin
          o[c*4+r] = t[c*4+r];
        end else begin
          o[c*4+r] = t[c*4+r] ^ all ^ gf_dbl(t[c*4+r] ^ t[c*4+((r+1)%4)]);
        end
      end
    end
    for (int i = 0; i < 16; i++) o[i] = o[i] ^ get_byte(rk, i);
    return {o[0], o[1], o[2], o[3], o[4], o[5], o[6], o[7],
            o[8], o[9], o[10], o[11], o[12], o[13], o[14], o[15]};
  endfunction

endpackage

[rtl/acfb_core.sv]
// Unrolled ten-round AES-128 block encryption with on-the-fly key schedule.
`timescale 1ns / 1ps
module acfb_core (
  input  acfb_pkg::block_t key_i,
  input  acfb_pkg::block_t blk_i,
  output acfb_pkg::block_t blk_o
);
  import acfb_pkg::*;

  block_t     st [11];
  block_t     rk [11];
  logic [7:0] rc [11];

  assign rk[0] = key_i;
  assign st[0] = blk_i ^ key_i;
  assign rc[0] = RconInit;

  for (genvar r = 1; r <= 10; r++) begin : g_round
    assign rk[r] = next_round_key(rk[r-1], rc[r-1]);
    assign rc[r] = gf_dbl(rc[r-1]);
    assign st[r] = cipher_round(st[r-1], rk[r], r == 10);
  end

  assign blk_o = st[10];
endmodule

[rtl/aes128_cfb_cipher.sv]
// Top level: AES-128 CFB-128 stream cipher with register interface.
// The result of an input word is registered in the output register when the word is accepted.
// Throughput: one word per cycle unless the output stalls; the unrolled ten-round path sits between
// the feedback register and the output register, setting the clock limit.
// Reset clears key, IV, direction and feedback to zero and empties the output.
`timescale 1ns / 1ps
module aes128_cfb_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] data_high_i,
  input  logic [63:0] data_low_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_high_o,
  output logic [63:0] out_low_o
);
  import acfb_pkg::*;

  block_t key_q, iv_q, fb_q, fb_d, out_q, ks, fb_sel, res;
  logic   dir_q, out_valid_q, accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;

  assign fb_sel = restart_i ? iv_q : fb_q;

  acfb_core u_core (
    .key_i(key_q),
    .blk_i(fb_sel),
    .blk_o(ks)
  );

  assign res  = {data_high_i, data_low_i} ^ ks;
  assign fb_d = dir_q ? {data_high_i, data_low_i} : res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      iv_q  <= '0;
      dir_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_KEY_HIGH:  key_q[127:64] <= cfg_data_i;
        REG_KEY_LOW:   key_q[63:0]   <= cfg_data_i;
        REG_IV_HIGH:   iv_q[127:64]  <= cfg_data_i;
        REG_IV_LOW:    iv_q[63:0]    <= cfg_data_i;
        REG_DIRECTION: dir_q         <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        fb_q        <= fb_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_high_o  = out_q[127:64];
  assign out_low_o   = out_q[63:0];
endmodule

[verif/aes128_cfb_cipher_tb.sv]
// Self-checking testbench for the AES-128 CFB-128 cipher block.
`timescale 1ns / 1ps
module aes128_cfb_cipher_tb;
  import acfb_pkg::*;

  localparam int NumRandom = 1750;
  localparam int WatchLimit = 5000;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        restart;
  } word_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_pair_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        restart;
    logic        known;
    logic [63:0] exp_hi;
    logic [63:0] exp_lo;
  } vec_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] data_high_i;
  logic [63:0] data_low_i;
  logic        restart_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] out_high_o;
  logic [63:0] out_low_o;

  aes128_cfb_cipher u_dut (.*);

  logic [127:0] key_m, iv_m, fb_m;
  logic         dir_m;
  block_pair_t  expected_q[$];
  int           mismatches;
  int           results_seen;
  int           idle_cycles;
  bit           quiet_mode;
  bit           long_hold;
  bit           timed_out;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] sbox_at(input logic [7:0] a);
    logic [7:0] tbl [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return tbl[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] encrypt_block(input logic [127:0] pt, input logic [127:0] k);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] rk [16];
    logic [7:0] w [4];
    logic [7:0] rc;
    logic [7:0] a0, a1, a2, a3, sum;
    logic [127:0] res;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = k[127-8*i -: 8];
      s[i] = pt[127-8*i -: 8] ^ rk[i];
    end
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          t[c*4+r] = sbox_at(s[((c + r) % 4)*4 + r]);
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
          sum = a0 ^ a1 ^ a2 ^ a3;
          t[c*4]   = a0 ^ sum ^ xtime(a0 ^ a1);
          t[c*4+1] = a1 ^ sum ^ xtime(a1 ^ a2);
          t[c*4+2] = a2 ^ sum ^ xtime(a2 ^ a3);
          t[c*4+3] = a3 ^ sum ^ xtime(a3 ^ a0);
        end
      end
      w[0] = sbox_at(rk[13]) ^ rc;
      w[1] = sbox_at(rk[14]);
      w[2] = sbox_at(rk[15]);
      w[3] = sbox_at(rk[12]);
      for (int i = 0; i < 4; i++) rk[i] = rk[i] ^ w[i];
      for (int i = 4; i < 16; i++) rk[i] = rk[i] ^ rk[i-4];
      rc = xtime(rc);
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  function automatic block_pair_t cfb_step(input word_t w);
    logic [127:0] din, dout;
    if (w.restart) fb_m = iv_m;
    din = {w.hi, w.lo};
    dout = din ^ encrypt_block(fb_m, key_m);
    fb_m = dir_m ? din : dout;
    return '{hi: dout[127:64], lo: dout[63:0]};
  endfunction

  task automatic write_reg(input reg_idx_e idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_KEY_HIGH:  key_m[127:64] = val;
      REG_KEY_LOW:   key_m[63:0] = val;
      REG_IV_HIGH:   iv_m[127:64] = val;
      REG_IV_LOW:    iv_m[63:0] = val;
      REG_DIRECTION: dir_m = val[0];
      default: ;
    endcase
  endtask

  task automatic setup_cipher(input logic [127:0] k, input logic [127:0] iv, input logic d);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    write_reg(REG_KEY_HIGH, k[127:64]);
    write_reg(REG_KEY_LOW, k[63:0]);
    write_reg(REG_IV_HIGH, iv[127:64]);
    write_reg(REG_IV_LOW, iv[63:0]);
    write_reg(REG_DIRECTION, {63'd0, d});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_word(input word_t w, input bit gaps);
    if (gaps && !quiet_mode && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_high_i <= w.hi;
    data_low_i <= w.lo;
    restart_i <= w.restart;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(cfb_step(w));
  endtask

  task automatic release_input();
    in_valid_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // receiver: random stall bursts, one long hold on request
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (40) @(posedge clk_i);
        long_hold = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    block_pair_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h", out_high_o, out_low_o);
      end else begin
        exp_w = expected_q.pop_front();
        if (exp_w.hi !== out_high_o || exp_w.lo !== out_low_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h %h, got %h %h",
                     exp_w.hi, exp_w.lo, out_high_o, out_low_o);
        end
      end
    end
  end

  // watchdog on cycles without any accepted word, delivered result or register write
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("timeout");
        $display("FAIL aes128_cfb_cipher");
        $finish;
      end
    end
  end

  initial begin
    vec_t        table_v[$];
    word_t       w;
    block_pair_t got;
    int          n_dir;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_KEY_HIGH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    data_high_i = '0;
    data_low_i = '0;
    restart_i = 1'b0;
    mismatches = 0;
    results_seen = 0;
    quiet_mode = 1'b0;
    long_hold = 1'b0;
    key_m = '0;
    iv_m = '0;
    fb_m = '0;
    dir_m = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset: zero key, zero feedback, so keystream is AES_0(0)
    table_v.push_back('{64'h0, 64'h0, 1'b0, 1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e});
    table_v.push_back('{64'hffffffffffffffff, 64'hffffffffffffffff, 1'b1, 1'b1,
                        64'h9916b42b1075d3c4, 64'h77b305a635cbd4d1});
    table_v.push_back('{64'h8000000000000000, 64'h1, 1'b0, 1'b0, 64'h0, 64'h0});
    table_v.push_back('{64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 1'b0, 64'h0, 64'h0});
    table_v.push_back('{64'hffffffffffffffff, 64'h0, 1'b1, 1'b0, 64'h0, 64'h0});
    foreach (table_v[i]) begin
      w = '{table_v[i].hi, table_v[i].lo, table_v[i].restart};
      send_word(w, 1'b0);
      if (table_v[i].known) begin
        got = expected_q[$];
        if (got.hi !== table_v[i].exp_hi || got.lo !== table_v[i].exp_lo) begin
          mismatches++;
          if (mismatches <= 10)
            $display("directed row %0d: expected %h %h, predicted %h %h", i,
                     table_v[i].exp_hi, table_v[i].exp_lo, got.hi, got.lo);
        end
      end
    end
    release_input();

    // standard CFB128 vector: first block
    setup_cipher(128'h2b7e151628aed2a6abf7158809cf4f3c,
                 128'h000102030405060708090a0b0c0d0e0f, 1'b0);
    send_word('{64'h6bc1bee22e409f96, 64'he93d7e117393172a, 1'b1}, 1'b0);
    got = expected_q[$];
    if (got.hi !== 64'h3b3fd92eb72dad20 || got.lo !== 64'h333449f8e83cfb4a) begin
      mismatches++;
      if (mismatches <= 10)
        $display("known-answer block: expected %h %h, predicted %h %h",
                 64'h3b3fd92eb72dad20, 64'h333449f8e83cfb4a, got.hi, got.lo);
    end
    send_word('{64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 1'b0}, 1'b0);
    release_input();
    setup_cipher({128{1'b1}}, {128{1'b1}}, 1'b1);
    send_word('{64'h3b3fd92eb72dad20, 64'h333449f8e83cfb4a, 1'b1}, 1'b0);
    send_word('{64'h0, 64'hffffffffffffffff, 1'b0}, 1'b0);
    // IV write alone does not reload the feedback
    release_input();
    setup_cipher({128{1'b1}}, 128'h0, 1'b0);
    send_word('{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0}, 1'b0);
    send_word('{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b1}, 1'b0);
    release_input();

    // random messages: restart at the head, random content, now and then a stray restart
    n_dir = 0;
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 200 == 0) begin
        release_input();
        setup_cipher({rand64(), rand64()}, {rand64(), rand64()}, n_dir[0]);
        n_dir++;
      end
      if (i == 600) long_hold = 1'b1;
      if (i == 900) begin
        release_input();
        while (expected_q.size() != 0) @(posedge clk_i);
      end
      if (i == NumRandom - 200) quiet_mode = 1'b1;
      w.hi = rand64();
      w.lo = rand64();
      w.restart = (i % 200 == 0) || ($urandom_range(0, 19) == 0);
      send_word(w, 1'b1);
    end
    release_input();

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Covered %0d result words over directed vectors and %0d random words,",
             results_seen, NumRandom);
    $display("both directions, restarts, and long output holds.");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASS aes128_cfb_cipher");
    end else begin
      $display("FAIL aes128_cfb_cipher");
    end
    $finish;
  end

endmodule
